FILE: sv/lbmt_pkg.sv
// Shared types and constants for the learning bridge MAC table.
package lbmt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int PORT_COUNT    = 16;

	localparam int MAC_W   = 48;
	localparam int PORT_W  = 4;
	localparam int AGE_W   = 16;
	localparam int PCMP_W  = 9;

	localparam logic [AGE_W-1:0] AGE_MAX       = '1;
	localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(15);

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef logic [MAC_W-1:0]  mac_t;
	typedef logic [PORT_W-1:0] port_t;
	typedef logic [AGE_W-1:0]  age_t;

endpackage

FILE: sv/learning_bridge_mac_table_unit.sv
// Learning bridge MAC table with aging: top level.
// Takes one request per cycle (frame header or aging tick) and gives one result per frame,
// registered in the input register and then in the result register; a tick gives none.
// All 16 entries are compared against source and destination in parallel between the input
// and result registers, so the table is learned, looked up and aged with no stall of its
// own; input stalls only while a finished result waits and the next frame is ready behind it.
// aging_timeout resets to 15; user writes with cfg_wr_en high only while idle, unchecked.
module learning_bridge_mac_table_unit import lbmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [47:0] src_mac,
	input  logic [47:0] dst_mac,
	input  logic [3:0]  ingress_port,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  out_port,
	output logic        flood,
	output logic        learn_full
);

	age_t timeout_q;

	logic  vld_s1;
	logic  op_s1;
	mac_t  src_s1;
	mac_t  dst_s1;
	port_t port_s1;

	mac_t                     entry_mac_q  [TABLE_ENTRIES];
	port_t                    entry_port_q [TABLE_ENTRIES];
	age_t                     entry_age_q  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] entry_valid_q;

	logic  out_valid_q;
	port_t out_port_q;
	logic  flood_q;
	logic  learn_full_q;

	logic                     proceed;
	logic                     do_frame;
	logic                     do_tick;
	logic                     port_ok;
	logic [TABLE_ENTRIES-1:0] src_hit;
	logic [TABLE_ENTRIES-1:0] dst_hit_old;
	logic [TABLE_ENTRIES-1:0] free_vec;
	logic [TABLE_ENTRIES-1:0] free_first;
	logic [TABLE_ENTRIES-1:0] learn_vec;
	logic [TABLE_ENTRIES-1:0] dst_vec;
	logic                     src_any;
	logic                     learn_en;
	logic                     full;
	logic                     same;
	logic                     dst_found;
	port_t                    port_old;
	port_t                    port_lookup;
	age_t                     age_inc [TABLE_ENTRIES];

	assign proceed  = vld_s1 && (op_s1 == OP_TICK || !out_valid_q || out_ready);
	assign in_ready = !vld_s1 || proceed;
	assign do_frame = proceed && op_s1 == OP_FRAME;
	assign do_tick  = proceed && op_s1 == OP_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= opcode;
			src_s1  <= src_mac;
			dst_s1  <= dst_mac;
			port_s1 <= ingress_port;
		end
	end

	always_comb begin
		port_old = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			src_hit[i]     = entry_valid_q[i] && entry_mac_q[i] == src_s1;
			dst_hit_old[i] = entry_valid_q[i] && entry_mac_q[i] == dst_s1;
			if (dst_hit_old[i]) begin
				port_old = port_old | entry_port_q[i];
			end
			age_inc[i] = (entry_age_q[i] == AGE_MAX) ? entry_age_q[i]
				: entry_age_q[i] + AGE_W'(1);
		end
		free_vec    = ~entry_valid_q;
		free_first  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
		port_ok     = PCMP_W'(port_s1) < PCMP_W'(PORT_COUNT);
		src_any     = |src_hit;
		learn_en    = port_ok && (src_any || |free_vec);
		full        = port_ok && !src_any && !(|free_vec);
		learn_vec   = src_any ? src_hit : free_first;
		same        = learn_en && src_s1 == dst_s1;
		dst_vec     = same ? learn_vec : dst_hit_old;
		dst_found   = same || |dst_hit_old;
		port_lookup = same ? port_s1 : port_old;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				entry_age_q[i] <= '0;
			end
		end else if (do_tick) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (entry_valid_q[i]) begin
					if (age_inc[i] >= timeout_q) begin
						entry_valid_q[i] <= 1'b0;
						entry_age_q[i]   <= '0;
					end else begin
						entry_age_q[i] <= age_inc[i];
					end
				end
			end
		end else if (do_frame) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (learn_en && learn_vec[i]) begin
					entry_valid_q[i] <= 1'b1;
					entry_age_q[i]   <= '0;
				end
				if (dst_vec[i]) begin
					entry_age_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_frame && learn_en) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (learn_vec[i]) begin
					entry_mac_q[i]  <= src_s1;
					entry_port_q[i] <= port_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_frame) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_frame) begin
			out_port_q   <= dst_found ? port_lookup : '0;
			flood_q      <= !dst_found;
			learn_full_q <= full;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_port   = out_port_q;
	assign flood      = flood_q;
	assign learn_full = learn_full_q;

endmodule

FILE: sv/lbmt_checker.sv
// Port-level checks for the learning bridge MAC table, bound to the top level.
module lbmt_checker import lbmt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] out_port,
	input logic       flood
);

	logic frame_acc;

	assign frame_acc = in_valid && in_ready && opcode == OP_FRAME;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_port) && $stable(flood))
		else $error("result changed while stalled");

	a_flood_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flood |-> out_port == '0)
		else $error("flood result carries a port");

	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(frame_acc, 2))
		else $error("result without a frame request two cycles before");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output free");

endmodule

bind learning_bridge_mac_table_unit lbmt_checker u_lbmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_port  (out_port),
	.flood     (flood)
);
